@@ sv/qdri_pkg.sv @@
`timescale 1ns / 1ps

package qdri_pkg;

	// field widths
	localparam int ODO_W      = 32;
	localparam int Q_W        = 16;
	localparam int QMAG_W     = Q_W + 1;

	// odometry step and its magnitude
	localparam int DLT_W      = ODO_W + 1;
	localparam int MAG_W      = DLT_W;

	// shared multiplier: wide operand by a 17-bit slice
	localparam int MUL_A_W    = 34;
	localparam int MUL_B_W    = 17;
	localparam int PROD_W     = MUL_A_W + MUL_B_W;
	localparam int HI_SH      = MUL_B_W;
	localparam int ACC_W      = 70;

	// square root
	localparam int RAD_W      = 68;
	localparam int ROOT_W     = RAD_W / 2;
	localparam int ROOT_STEPS = ROOT_W;
	localparam int REM_W      = ROOT_W + 4;

	// rotation coefficients and step scaling
	localparam int COEF_W     = 36;
	localparam int FRAC_SH    = 28;
	localparam int RND_BIT    = FRAC_SH - 1;
	localparam int M_W        = 39;
	localparam int STEP_W     = M_W + 1;
	localparam int SUM_W      = STEP_W + 1;
	localparam int CNT_W      = 6;

	localparam logic signed [COEF_W-1:0] COEF_ONE = COEF_W'(64'sd268435456);
	localparam logic signed [SUM_W-1:0]  SUM_MAX  = SUM_W'(64'sd2147483647);
	localparam logic signed [SUM_W-1:0]  SUM_MIN  = SUM_W'(-64'sd2147483648);
	localparam logic signed [Q_W-1:0]    Q_ONE    = Q_W'(32'sd16384);

	// sequencer last-step indices
	localparam logic [CNT_W-1:0] COEF_LAST  = CNT_W'(5);
	localparam logic [CNT_W-1:0] SQ_LAST    = CNT_W'(5);
	localparam logic [CNT_W-1:0] ROOT_LAST  = CNT_W'(ROOT_STEPS - 1);
	localparam logic [CNT_W-1:0] SCALE_LAST = CNT_W'(10);
	localparam logic [1:0]       PH_UPD     = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COEF,
		ST_SQ,
		ST_ROOT,
		ST_SCALE,
		ST_DONE
	} state_t;

	typedef enum logic {
		OP_ORIENT = 1'b0,
		OP_ODO    = 1'b1
	} op_t;

	function automatic logic [QMAG_W-1:0] mag16(input logic signed [Q_W-1:0] v);
		logic signed [QMAG_W-1:0] e;
		e = QMAG_W'(v);
		return v[Q_W-1] ? QMAG_W'(-e) : QMAG_W'(e);
	endfunction

	function automatic logic signed [ODO_W-1:0] sat_add(
		input logic signed [ODO_W-1:0]  a,
		input logic signed [STEP_W-1:0] b
	);
		logic signed [SUM_W-1:0] s;
		s = SUM_W'(a) + SUM_W'(b);
		if (s > SUM_MAX)
			return SUM_MAX[ODO_W-1:0];
		else if (s < SUM_MIN)
			return SUM_MIN[ODO_W-1:0];
		else
			return s[ODO_W-1:0];
	endfunction

endpackage

@@ sv/quaternion_dead_reckoning_integrator.sv @@
// Dead-reckoning integrator: heading quaternion times odometry step length.
// A position transaction after the first runs 6 coefficient, 6 square, 34 root
// and 9 scale steps, then publishes through the done state and output register,
// all on one shared 34x17 multiply-accumulate unit and a one-bit-a-step root.
// Other transactions go from accept to the done state and the output register.
// No new transaction is taken until the last one is published. arst_n clears
// estimate, previous odometry and valid flag, and loads the identity heading.
`timescale 1ns / 1ps

module quaternion_dead_reckoning_integrator (
	input  logic                                clk,
	input  logic                                arst_n,

	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                operation,
	input  logic signed [qdri_pkg::Q_W-1:0]     quat_w,
	input  logic signed [qdri_pkg::Q_W-1:0]     quat_x,
	input  logic signed [qdri_pkg::Q_W-1:0]     quat_y,
	input  logic signed [qdri_pkg::Q_W-1:0]     quat_z,
	input  logic signed [qdri_pkg::ODO_W-1:0]   odo_x,
	input  logic signed [qdri_pkg::ODO_W-1:0]   odo_y,
	input  logic signed [qdri_pkg::ODO_W-1:0]   odo_z,

	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [qdri_pkg::ODO_W-1:0]   est_x,
	output logic signed [qdri_pkg::ODO_W-1:0]   est_y,
	output logic signed [qdri_pkg::ODO_W-1:0]   est_z,
	output logic                                pose_valid,
	output logic signed [qdri_pkg::Q_W-1:0]     heading_w,
	output logic signed [qdri_pkg::Q_W-1:0]     heading_x,
	output logic signed [qdri_pkg::Q_W-1:0]     heading_y,
	output logic signed [qdri_pkg::Q_W-1:0]     heading_z
);

	// ---------------------------------------------------------------
	// Architectural state
	// ---------------------------------------------------------------
	logic                               seen_q;
	logic signed [qdri_pkg::ODO_W-1:0]  prev_q [3];
	logic signed [qdri_pkg::ODO_W-1:0]  est_q  [3];
	logic signed [qdri_pkg::Q_W-1:0]    qw_q, qx_q, qy_q, qz_q;

	// working registers for one position transaction
	logic [qdri_pkg::MAG_W-1:0]         dmag_q [3];
	logic [qdri_pkg::MAG_W-1:0]         cmag_q [3];
	logic                               csign_q [3];
	logic signed [qdri_pkg::ACC_W-1:0]  acc_q;
	logic [qdri_pkg::REM_W-1:0]         rem_q;
	logic [qdri_pkg::ROOT_W-1:0]        root_q;

	// output register: decouples result hand-off from the next accept
	logic                               out_valid_q;
	logic signed [qdri_pkg::ODO_W-1:0]  out_est_q [3];
	logic                               out_pose_q;
	logic signed [qdri_pkg::Q_W-1:0]    out_qw_q, out_qx_q, out_qy_q, out_qz_q;

	// sequencer
	qdri_pkg::state_t                   state_q, state_d;
	logic [qdri_pkg::CNT_W-1:0]         step_q, step_d;
	logic                               in_acc;
	logic                               out_load;

	// ---------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qdri_pkg::ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		step_d   = step_q;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			qdri_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				step_d   = '0;
				if (in_valid) begin
					// orientation or first sample: nothing to integrate
					if (operation == qdri_pkg::OP_ORIENT || !seen_q)
						state_d = qdri_pkg::ST_DONE;
					else
						state_d = qdri_pkg::ST_COEF;
				end
			end
			qdri_pkg::ST_COEF: begin
				if (step_q == qdri_pkg::COEF_LAST) begin
					state_d = qdri_pkg::ST_SQ;
					step_d  = '0;
				end else begin
					step_d  = step_q + qdri_pkg::CNT_W'(1);
				end
			end
			qdri_pkg::ST_SQ: begin
				if (step_q == qdri_pkg::SQ_LAST) begin
					state_d = qdri_pkg::ST_ROOT;
					step_d  = '0;
				end else begin
					step_d  = step_q + qdri_pkg::CNT_W'(1);
				end
			end
			qdri_pkg::ST_ROOT: begin
				if (step_q == qdri_pkg::ROOT_LAST) begin
					state_d = qdri_pkg::ST_SCALE;
					step_d  = '0;
				end else begin
					step_d  = step_q + qdri_pkg::CNT_W'(1);
				end
			end
			qdri_pkg::ST_SCALE: begin
				// step[3:2] = axis, step[1:0] = low mul, high mul, update
				if (step_q == qdri_pkg::SCALE_LAST) begin
					state_d = qdri_pkg::ST_DONE;
					step_d  = '0;
				end else if (step_q[1:0] == qdri_pkg::PH_UPD) begin
					step_d  = step_q + qdri_pkg::CNT_W'(2);
				end else begin
					step_d  = step_q + qdri_pkg::CNT_W'(1);
				end
			end
			qdri_pkg::ST_DONE: begin
				out_load = !out_valid_q || out_ready;
				if (out_load)
					state_d = qdri_pkg::ST_IDLE;
			end
			default: begin
				state_d = qdri_pkg::ST_IDLE;
			end
		endcase
	end

	assign in_acc = in_valid && in_ready;

	// ---------------------------------------------------------------
	// Shared multiply-accumulate operand selection
	// ---------------------------------------------------------------
	logic [qdri_pkg::QMAG_W-1:0]        qm_w, qm_x, qm_y, qm_z;
	logic                               sg_w, sg_x, sg_y, sg_z;
	logic [qdri_pkg::MUL_A_W-1:0]       mul_a;
	logic [qdri_pkg::MUL_B_W-1:0]       mul_b;
	logic                               mul_hi, mul_neg;
	logic                               acc_en, acc_load, acc_rnd;
	logic                               coef_wr;
	logic [1:0]                         coef_idx;
	logic                               root_clr, root_en;
	logic                               est_wr;
	logic [1:0]                         sq_idx, ax_idx;

	assign qm_w   = qdri_pkg::mag16(qw_q);
	assign qm_x   = qdri_pkg::mag16(qx_q);
	assign qm_y   = qdri_pkg::mag16(qy_q);
	assign qm_z   = qdri_pkg::mag16(qz_q);
	assign sg_w   = qw_q[qdri_pkg::Q_W-1];
	assign sg_x   = qx_q[qdri_pkg::Q_W-1];
	assign sg_y   = qy_q[qdri_pkg::Q_W-1];
	assign sg_z   = qz_q[qdri_pkg::Q_W-1];
	assign sq_idx = step_q[2:1];
	assign ax_idx = step_q[3:2];

	always_comb begin
		mul_a    = '0;
		mul_b    = '0;
		mul_hi   = 1'b0;
		mul_neg  = 1'b0;
		acc_en   = 1'b0;
		acc_load = 1'b0;
		acc_rnd  = 1'b0;
		coef_wr  = 1'b0;
		coef_idx = 2'd0;
		root_clr = 1'b0;
		root_en  = 1'b0;
		est_wr   = 1'b0;
		case (state_q)
			qdri_pkg::ST_COEF: begin
				// y*y+z*z, x*y+w*z, x*z-w*y; each pair summed in acc
				acc_en = 1'b1;
				case (step_q[2:0])
					3'd0: begin
						mul_a    = qdri_pkg::MUL_A_W'(qm_y);
						mul_b    = qm_y;
						acc_load = 1'b1;
					end
					3'd1: begin
						mul_a    = qdri_pkg::MUL_A_W'(qm_z);
						mul_b    = qm_z;
					end
					3'd2: begin
						mul_a    = qdri_pkg::MUL_A_W'(qm_x);
						mul_b    = qm_y;
						mul_neg  = sg_x ^ sg_y;
						acc_load = 1'b1;
						coef_wr  = 1'b1;
						coef_idx = 2'd0;
					end
					3'd3: begin
						mul_a    = qdri_pkg::MUL_A_W'(qm_w);
						mul_b    = qm_z;
						mul_neg  = sg_w ^ sg_z;
					end
					3'd4: begin
						mul_a    = qdri_pkg::MUL_A_W'(qm_x);
						mul_b    = qm_z;
						mul_neg  = sg_x ^ sg_z;
						acc_load = 1'b1;
						coef_wr  = 1'b1;
						coef_idx = 2'd1;
					end
					3'd5: begin
						mul_a    = qdri_pkg::MUL_A_W'(qm_w);
						mul_b    = qm_y;
						mul_neg  = !(sg_w ^ sg_y);
					end
					default: begin
						acc_en   = 1'b0;
					end
				endcase
			end
			qdri_pkg::ST_SQ: begin
				// squared step length, each square as two partial products
				acc_en   = 1'b1;
				mul_a    = qdri_pkg::MUL_A_W'(dmag_q[sq_idx]);
				mul_hi   = step_q[0];
				mul_b    = step_q[0] ?
					qdri_pkg::MUL_B_W'(dmag_q[sq_idx][qdri_pkg::MAG_W-1:qdri_pkg::HI_SH]) :
					dmag_q[sq_idx][qdri_pkg::HI_SH-1:0];
				acc_load = (step_q == '0);
				coef_wr  = (step_q == '0);
				coef_idx = 2'd2;
				root_clr = (step_q == qdri_pkg::SQ_LAST);
			end
			qdri_pkg::ST_ROOT: begin
				root_en  = 1'b1;
			end
			qdri_pkg::ST_SCALE: begin
				if (step_q[1:0] == qdri_pkg::PH_UPD) begin
					est_wr   = 1'b1;
				end else begin
					// length times |coefficient|, with the half-LSB rounding term
					acc_en   = 1'b1;
					mul_a    = root_q;
					mul_hi   = step_q[0];
					mul_b    = step_q[0] ?
						qdri_pkg::MUL_B_W'(cmag_q[ax_idx][qdri_pkg::MAG_W-1:qdri_pkg::HI_SH]) :
						cmag_q[ax_idx][qdri_pkg::HI_SH-1:0];
					acc_load = !step_q[0];
					acc_rnd  = !step_q[0];
				end
			end
			default: begin
			end
		endcase
	end

	// ---------------------------------------------------------------
	// Multiply-accumulate unit
	// ---------------------------------------------------------------
	logic [qdri_pkg::PROD_W-1:0]        prod;
	logic signed [qdri_pkg::ACC_W-1:0]  prod_sh;
	logic signed [qdri_pkg::ACC_W-1:0]  acc_base;
	logic signed [qdri_pkg::ACC_W-1:0]  acc_d;

	assign prod    = qdri_pkg::PROD_W'(mul_a) * qdri_pkg::PROD_W'(mul_b);
	assign prod_sh = mul_hi ?
		$signed(qdri_pkg::ACC_W'(prod) << qdri_pkg::HI_SH) :
		$signed(qdri_pkg::ACC_W'(prod));

	always_comb begin
		if (!acc_load)
			acc_base = acc_q;
		else if (acc_rnd)
			acc_base = $signed(qdri_pkg::ACC_W'(1) << qdri_pkg::RND_BIT);
		else
			acc_base = '0;
		acc_d = mul_neg ? acc_base - prod_sh : acc_base + prod_sh;
	end

	// ---------------------------------------------------------------
	// Coefficient capture: cx = 1 - 2(y*y+z*z), cy, cz = 2*(pair sum)
	// ---------------------------------------------------------------
	logic signed [qdri_pkg::COEF_W-1:0] acc_c;
	logic signed [qdri_pkg::COEF_W-1:0] coef_v;

	assign acc_c  = acc_q[qdri_pkg::COEF_W-1:0];
	assign coef_v = (coef_idx == 2'd0) ? qdri_pkg::COEF_ONE - (acc_c <<< 1) : (acc_c <<< 1);

	always_ff @(posedge clk) begin
		if (coef_wr) begin
			csign_q[coef_idx] <= coef_v[qdri_pkg::COEF_W-1];
			cmag_q[coef_idx]  <= coef_v[qdri_pkg::COEF_W-1] ?
				qdri_pkg::MAG_W'(-coef_v) : qdri_pkg::MAG_W'(coef_v);
		end
	end

	// ---------------------------------------------------------------
	// Accumulator / radicand and restoring square root (2 bits per step)
	// ---------------------------------------------------------------
	logic [qdri_pkg::REM_W-1:0]         rem_sh;
	logic [qdri_pkg::REM_W-1:0]         trial;
	logic                               take;

	assign rem_sh = {rem_q[qdri_pkg::REM_W-3:0], acc_q[qdri_pkg::RAD_W-1 -: 2]};
	assign trial  = qdri_pkg::REM_W'({root_q, 2'b01});
	assign take   = (rem_sh >= trial);

	always_ff @(posedge clk) begin
		if (acc_en)
			acc_q <= acc_d;
		else if (root_en)
			acc_q <= acc_q <<< 2;

		if (root_clr) begin
			rem_q  <= '0;
			root_q <= '0;
		end else if (root_en) begin
			rem_q  <= take ? rem_sh - trial : rem_sh;
			root_q <= {root_q[qdri_pkg::ROOT_W-2:0], take};
		end
	end

	// ---------------------------------------------------------------
	// Step: round(L*c / 2^28) already in acc, apply sign, saturate
	// ---------------------------------------------------------------
	logic [qdri_pkg::M_W-1:0]           m_val;
	logic signed [qdri_pkg::STEP_W-1:0] step_v;

	assign m_val  = acc_q[qdri_pkg::FRAC_SH +: qdri_pkg::M_W];
	assign step_v = csign_q[ax_idx] ?
		-$signed({1'b0, m_val}) : $signed({1'b0, m_val});

	// ---------------------------------------------------------------
	// Architectural state update
	// ---------------------------------------------------------------
	logic signed [qdri_pkg::ODO_W-1:0]  odo_in [3];
	assign odo_in[0] = odo_x;
	assign odo_in[1] = odo_y;
	assign odo_in[2] = odo_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
			qw_q   <= qdri_pkg::Q_ONE;
			qx_q   <= '0;
			qy_q   <= '0;
			qz_q   <= '0;
			for (int i = 0; i < 3; i++) begin
				prev_q[i] <= '0;
				est_q[i]  <= '0;
			end
		end else begin
			if (in_acc) begin
				if (operation == qdri_pkg::OP_ORIENT) begin
					qw_q <= quat_w;
					qx_q <= quat_x;
					qy_q <= quat_y;
					qz_q <= quat_z;
				end else begin
					seen_q <= 1'b1;
					for (int i = 0; i < 3; i++)
						prev_q[i] <= odo_in[i];
				end
			end
			if (est_wr)
				est_q[ax_idx] <= qdri_pkg::sat_add(est_q[ax_idx], step_v);
		end
	end

	// per-axis step magnitude, taken against the old previous position
	always_ff @(posedge clk) begin
		if (in_acc) begin
			for (int i = 0; i < 3; i++) begin
				logic signed [qdri_pkg::DLT_W-1:0] dlt;
				dlt = qdri_pkg::DLT_W'(odo_in[i]) - qdri_pkg::DLT_W'(prev_q[i]);
				dmag_q[i] <= dlt[qdri_pkg::DLT_W-1] ?
					qdri_pkg::MAG_W'(-dlt) : qdri_pkg::MAG_W'(dlt);
			end
		end
	end

	// ---------------------------------------------------------------
	// Output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_pose_q  <= 1'b0;
			out_qw_q    <= qdri_pkg::Q_ONE;
			out_qx_q    <= '0;
			out_qy_q    <= '0;
			out_qz_q    <= '0;
			for (int i = 0; i < 3; i++)
				out_est_q[i] <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				out_pose_q  <= seen_q;
				out_qw_q    <= qw_q;
				out_qx_q    <= qx_q;
				out_qy_q    <= qy_q;
				out_qz_q    <= qz_q;
				for (int i = 0; i < 3; i++)
					out_est_q[i] <= est_q[i];
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign est_x      = out_est_q[0];
	assign est_y      = out_est_q[1];
	assign est_z      = out_est_q[2];
	assign pose_valid = out_pose_q;
	assign heading_w  = out_qw_q;
	assign heading_x  = out_qx_q;
	assign heading_y  = out_qy_q;
	assign heading_z  = out_qz_q;

endmodule

@@ sv/qdri_checker.sv @@
`timescale 1ns / 1ps

module qdri_checker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	input  logic                                in_ready,
	input  logic                                operation,
	input  logic signed [qdri_pkg::Q_W-1:0]     quat_w,
	input  logic                                out_valid,
	input  logic                                out_ready,
	input  logic signed [qdri_pkg::ODO_W-1:0]   est_x,
	input  logic                                pose_valid,
	input  logic signed [qdri_pkg::Q_W-1:0]     heading_w
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(est_x) && $stable(heading_w))
		else $error("result changed while stalled");

	// every transaction keeps the block busy past its accept, so no back-to-back accepts
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted on consecutive cycles");

	// the pose flag never drops once set
	a_pose_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(pose_valid))
		else $error("pose_valid fell");

	// an orientation transaction into an empty output shows its heading via the done state and output register
	a_orient_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && operation == qdri_pkg::OP_ORIENT && !out_valid
		|=> ##1 out_valid && heading_w == $past(quat_w, 2))
		else $error("orientation result missing or wrong");

endmodule

bind quaternion_dead_reckoning_integrator qdri_checker u_qdri_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_ready   (in_ready),
	.operation  (operation),
	.quat_w     (quat_w),
	.out_valid  (out_valid),
	.out_ready  (out_ready),
	.est_x      (est_x),
	.pose_valid (pose_valid),
	.heading_w  (heading_w)
);
